// ----- hdl/rsas_pkg.sv -----
// rsas_pkg: shared types, codes and the control program of the rotated array search
`timescale 1ns / 1ps

package rsas_pkg;

	localparam int DEPTH_DEF = 4096;
	localparam int VALUE_W   = 16;
	localparam int POS_W     = 12;
	localparam int UPC_W     = 5;

	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_APPEND = 2'd1;
	localparam logic [1:0] MODE_SEARCH = 2'd2;

	typedef logic [UPC_W-1:0] upc_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_LO,
		RD_HI,
		RD_M
	} rd_sel_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_INIT,
		OP_MID,
		OP_HI_M,
		OP_HI_M1,
		OP_LO_M1,
		OP_MISC
	} alu_op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NOT_SEARCH,
		C_LO_GT_HI,
		C_ELO_LE_RD,
		C_ELO_GT_RD,
		C_KEY_IN,
		C_NOT_WRAP,
		C_RD_GT_KEY,
		C_RD_LT_KEY
	} cond_t;

	typedef enum logic [1:0] {
		FIN_NONE,
		FIN_FOUND,
		FIN_MISS,
		FIN_MISC
	} fin_t;

	typedef struct packed {
		rd_sel_t rd;
		logic    ld_elo;
		alu_op_t op;
		cond_t   cond;
		upc_t    target;
		fin_t    fin;
	} ctl_word_t;

	// sequencer to datapath
	typedef struct packed {
		logic      load;
		logic      en;
		ctl_word_t cw;
	} seq_ctl_t;

	// datapath to sequencer
	typedef struct packed {
		logic not_search;
		logic lo_gt_hi;
		logic elo_le_rd;
		logic elo_gt_rd;
		logic key_in;
		logic not_wrap;
		logic rd_gt_key;
		logic rd_lt_key;
		logic out_hold;
	} dp_flags_t;

	// program labels
	localparam upc_t U_START   = 5'd0;
	localparam upc_t U_OL      = 5'd1;
	localparam upc_t U_RD_LO   = 5'd2;
	localparam upc_t U_RD_HI   = 5'd3;
	localparam upc_t U_SORTED  = 5'd4;
	localparam upc_t U_RD_M    = 5'd5;
	localparam upc_t U_LEFT    = 5'd6;
	localparam upc_t U_KEY_IN  = 5'd7;
	localparam upc_t U_GO_R    = 5'd8;
	localparam upc_t U_WRAP    = 5'd9;
	localparam upc_t U_GO_L    = 5'd10;
	localparam upc_t U_TO_BS   = 5'd11;
	localparam upc_t U_BS      = 5'd12;
	localparam upc_t U_BS_RD   = 5'd13;
	localparam upc_t U_BS_GT   = 5'd14;
	localparam upc_t U_BS_LT   = 5'd15;
	localparam upc_t U_FOUND   = 5'd16;
	localparam upc_t U_BS_HI   = 5'd17;
	localparam upc_t U_BS_LO   = 5'd18;
	localparam upc_t U_MISS    = 5'd19;
	localparam upc_t U_MISC    = 5'd20;

	function automatic ctl_word_t mk(input rd_sel_t r, input logic l, input alu_op_t o,
			input cond_t c, input upc_t t, input fin_t f);
		ctl_word_t w;
		w.rd     = r;
		w.ld_elo = l;
		w.op     = o;
		w.cond   = c;
		w.target = t;
		w.fin    = f;
		return w;
	endfunction

	// control store; a taken jump goes to target, otherwise the next step
	function automatic ctl_word_t ucode_rom(input upc_t a);
		ctl_word_t w;
		case (a)
			U_START:  w = mk(RD_NONE, 1'b0, OP_INIT,  C_NOT_SEARCH, U_MISC,  FIN_NONE);
			U_OL:     w = mk(RD_NONE, 1'b0, OP_NOP,   C_LO_GT_HI,   U_MISS,  FIN_NONE);
			U_RD_LO:  w = mk(RD_LO,   1'b0, OP_NOP,   C_NEVER,      U_START, FIN_NONE);
			U_RD_HI:  w = mk(RD_HI,   1'b1, OP_NOP,   C_NEVER,      U_START, FIN_NONE);
			U_SORTED: w = mk(RD_NONE, 1'b0, OP_MID,   C_ELO_LE_RD,  U_BS,    FIN_NONE);
			U_RD_M:   w = mk(RD_M,    1'b0, OP_NOP,   C_NEVER,      U_START, FIN_NONE);
			U_LEFT:   w = mk(RD_NONE, 1'b0, OP_NOP,   C_ELO_GT_RD,  U_WRAP,  FIN_NONE);
			U_KEY_IN: w = mk(RD_NONE, 1'b0, OP_NOP,   C_KEY_IN,     U_TO_BS, FIN_NONE);
			U_GO_R:   w = mk(RD_NONE, 1'b0, OP_LO_M1, C_ALWAYS,     U_OL,    FIN_NONE);
			U_WRAP:   w = mk(RD_NONE, 1'b0, OP_NOP,   C_NOT_WRAP,   U_GO_R,  FIN_NONE);
			U_GO_L:   w = mk(RD_NONE, 1'b0, OP_HI_M,  C_ALWAYS,     U_OL,    FIN_NONE);
			U_TO_BS:  w = mk(RD_NONE, 1'b0, OP_HI_M,  C_NEVER,      U_START, FIN_NONE);
			U_BS:     w = mk(RD_NONE, 1'b0, OP_MID,   C_LO_GT_HI,   U_MISS,  FIN_NONE);
			U_BS_RD:  w = mk(RD_M,    1'b0, OP_NOP,   C_NEVER,      U_START, FIN_NONE);
			U_BS_GT:  w = mk(RD_NONE, 1'b0, OP_NOP,   C_RD_GT_KEY,  U_BS_HI, FIN_NONE);
			U_BS_LT:  w = mk(RD_NONE, 1'b0, OP_NOP,   C_RD_LT_KEY,  U_BS_LO, FIN_NONE);
			U_FOUND:  w = mk(RD_NONE, 1'b0, OP_NOP,   C_NEVER,      U_START, FIN_FOUND);
			U_BS_HI:  w = mk(RD_NONE, 1'b0, OP_HI_M1, C_ALWAYS,     U_BS,    FIN_NONE);
			U_BS_LO:  w = mk(RD_NONE, 1'b0, OP_LO_M1, C_ALWAYS,     U_BS,    FIN_NONE);
			U_MISS:   w = mk(RD_NONE, 1'b0, OP_NOP,   C_NEVER,      U_START, FIN_MISS);
			U_MISC:   w = mk(RD_NONE, 1'b0, OP_MISC,  C_NEVER,      U_START, FIN_MISC);
			default:  w = mk(RD_NONE, 1'b0, OP_NOP,   C_NEVER,      U_START, FIN_MISS);
		endcase
		return w;
	endfunction

endpackage

// ----- hdl/rsas_seq.sv -----
// rsas_seq: step counter, control store lookup and jump logic
`timescale 1ns / 1ps

module rsas_seq
	import rsas_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dp_flags_t flags,
	output seq_ctl_t  ctl
);

	seq_state_t state_q, state_d;
	upc_t       upc_q, upc_d;
	ctl_word_t  cw;
	logic       taken;
	logic       step_en;

	assign cw = ucode_rom(upc_q);

	always_comb begin
		case (cw.cond)
			C_NEVER:      taken = 1'b0;
			C_ALWAYS:     taken = 1'b1;
			C_NOT_SEARCH: taken = flags.not_search;
			C_LO_GT_HI:   taken = flags.lo_gt_hi;
			C_ELO_LE_RD:  taken = flags.elo_le_rd;
			C_ELO_GT_RD:  taken = flags.elo_gt_rd;
			C_KEY_IN:     taken = flags.key_in;
			C_NOT_WRAP:   taken = flags.not_wrap;
			C_RD_GT_KEY:  taken = flags.rd_gt_key;
			C_RD_LT_KEY:  taken = flags.rd_lt_key;
			default:      taken = 1'b0;
		endcase
	end

	// a finishing step waits while the previous result word is still unread
	assign step_en = (state_q == SEQ_RUN) && !((cw.fin != FIN_NONE) && flags.out_hold);

	always_comb begin
		state_d = state_q;
		upc_d   = upc_q;
		case (state_q)
			SEQ_IDLE: begin
				if (in_valid) begin
					state_d = SEQ_RUN;
					upc_d   = U_START;
				end
			end
			SEQ_RUN: begin
				if (step_en) begin
					if (cw.fin != FIN_NONE) begin
						state_d = SEQ_IDLE;
					end else if (taken) begin
						upc_d = cw.target;
					end else begin
						upc_d = upc_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = (state_q == SEQ_IDLE);
		ctl.load = in_valid && (state_q == SEQ_IDLE);
		ctl.en   = step_en;
		ctl.cw   = cw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			upc_q   <= U_START;
		end else begin
			state_q <= state_d;
			upc_q   <= upc_d;
		end
	end

endmodule

// ----- hdl/rsas_datapath.sv -----
// rsas_datapath: element memory, range registers, comparators and result register
`timescale 1ns / 1ps

module rsas_datapath
	import rsas_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  seq_ctl_t                  ctl,
	output dp_flags_t                 flags,
	input  logic [1:0]                mode,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      found,
	output logic [POS_W-1:0]          position,
	output logic                      status
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam logic signed [SW-1:0] ONE_S = 1;

	logic signed [VALUE_W-1:0] mem [DEPTH];
	logic signed [VALUE_W-1:0] rd_q;
	logic signed [VALUE_W-1:0] elo_q;
	logic signed [VALUE_W-1:0] key_q;
	logic [1:0]                mode_q;
	logic [CW-1:0]             count_q;
	logic signed [SW-1:0]      lo_q, hi_q;
	logic [IW-1:0]             m_q;
	logic signed [SW-1:0]      m_s;
	logic signed [SW:0]        sum_s;
	logic [IW-1:0]             rd_addr;
	logic                      full;
	logic                      do_append;
	logic                      out_valid_q, found_q, status_q;
	logic [POS_W-1:0]          position_q;
	logic [31:0]               m_wide;

	assign m_s       = SW'(m_q);
	assign sum_s     = (SW+1)'(lo_q) + (SW+1)'(hi_q);
	assign full      = (count_q == CW'(DEPTH));
	assign do_append = ctl.en && (ctl.cw.op == OP_MISC) && (mode_q == MODE_APPEND) && !full;
	assign m_wide    = 32'(m_q);

	always_comb begin
		case (ctl.cw.rd)
			RD_LO:   rd_addr = lo_q[IW-1:0];
			RD_HI:   rd_addr = hi_q[IW-1:0];
			RD_M:    rd_addr = m_q;
			default: rd_addr = m_q;
		endcase
	end

	// single port element store, read data held until the next read
	always_ff @(posedge clk) begin
		if (do_append) begin
			mem[count_q[IW-1:0]] <= key_q;
		end
		if (ctl.en && (ctl.cw.rd != RD_NONE)) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mode_q <= mode;
			key_q  <= value;
		end
		if (ctl.en && ctl.cw.ld_elo) begin
			elo_q <= rd_q;
		end
		if (ctl.en) begin
			case (ctl.cw.op)
				OP_INIT: begin
					lo_q <= '0;
					hi_q <= SW'(count_q) - ONE_S;
				end
				OP_MID:   m_q  <= sum_s[IW:1];
				OP_HI_M:  hi_q <= m_s;
				OP_HI_M1: hi_q <= m_s - ONE_S;
				OP_LO_M1: lo_q <= m_s + ONE_S;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.en && (ctl.cw.op == OP_MISC)) begin
			if (mode_q == MODE_CLEAR) begin
				count_q <= '0;
			end else if (do_append) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.en && (ctl.cw.fin != FIN_NONE)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en && (ctl.cw.fin != FIN_NONE)) begin
			found_q    <= (ctl.cw.fin == FIN_FOUND);
			position_q <= (ctl.cw.fin == FIN_FOUND) ? m_wide[POS_W-1:0] : '0;
			status_q   <= (ctl.cw.fin == FIN_MISC) && (mode_q == MODE_APPEND) && full;
		end
	end

	always_comb begin
		flags.not_search = (mode_q != MODE_SEARCH);
		flags.lo_gt_hi   = (lo_q > hi_q);
		flags.elo_le_rd  = (elo_q <= rd_q);
		flags.elo_gt_rd  = (elo_q > rd_q);
		flags.key_in     = (key_q >= elo_q) && (key_q <= rd_q);
		flags.not_wrap   = (key_q < elo_q) && (key_q > rd_q);
		flags.rd_gt_key  = (rd_q > key_q);
		flags.rd_lt_key  = (rd_q < key_q);
		flags.out_hold   = out_valid_q && !out_ready;
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign position  = position_q;
	assign status    = status_q;

endmodule

// ----- hdl/rotated_sorted_array_search_core.sv -----
// rotated_sorted_array_search_core: top level of the rotated sorted array search block
//
// input channel in_valid/in_ready carries one word: mode and value. mode clear empties
// the array, append stores value at the next slot (status 1 when DEPTH entries are
// already held), search looks for value in the stored rotated ascending run.
// output channel out_valid/out_ready returns one word per input: found, position, status.
// one word is worked on at a time; in_ready is high while the sequencer is idle, and the
// next word is taken even while the last result still waits in the output register.
// clear and append go from the set-up step straight to the finishing step, and in_ready
// is high again while their result word is shown.
// a search takes a set-up step, halving passes over an unsorted range, a move to a
// sorted range, binary search probes and a final step to report a hit or a miss; each
// pass and probe is split into steps around the single read port of the element
// memory, at most one read per step.
// if the receiver stalls, the finishing step waits until the held result is taken.
// reset empties the array and clears the sequencer and out_valid; memory contents
// are not cleared and are only read below the fill count.
`timescale 1ns / 1ps

module rotated_sorted_array_search_core
	import rsas_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                mode,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      found,
	output logic [POS_W-1:0]          position,
	output logic                      status
);

	seq_ctl_t  ctl;
	dp_flags_t flags;

	rsas_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.flags    (flags),
		.ctl      (ctl)
	);

	rsas_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.flags     (flags),
		.mode      (mode),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found     (found),
		.position  (position),
		.status    (status)
	);

endmodule

// ----- hdl/rsas_checker.sv -----
// rsas_checker: port level assertions for the rotated array search block, and its bind
`timescale 1ns / 1ps

module rsas_checker
	import rsas_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      found,
	input logic [POS_W-1:0]          position,
	input logic                      status
);

	// no result word may be shown once reset has been seen low at a clock edge
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("out_valid high during reset");

	// in_ready is low in the cycle after a taken word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after an accepted word");

	// a new result only appears out of a busy period
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without work in progress");

	// a miss reports position zero and a hit never flags a dropped append
	a_result_coherent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (found ? !status : (position == '0)))
		else $error("inconsistent result fields");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(position)
			&& $stable(status))
		else $error("stalled result word changed");

endmodule

bind rotated_sorted_array_search_core rsas_checker u_rsas_checker (.*);

// ----- bench/tb_top.sv -----
// tb_top: self-checking bench for the rotated sorted array search core
`timescale 1ns / 1ps

module tb_top;
	import rsas_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_FULL = 1'b1;
	localparam int FILL_WORDS = 64;
	localparam int RANDOM_WORDS = 320;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic             found;
		logic [POS_W-1:0] position;
		logic             status;
	} search_word_t;

	typedef struct {
		logic [1:0]                m;
		logic signed [VALUE_W-1:0] v;
		bit                        typed;
		search_word_t              res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] mode = MODE_CLEAR;
	logic signed [VALUE_W-1:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic found;
	logic [POS_W-1:0] position;
	logic status;

	// mirror of the array contents
	logic signed [VALUE_W-1:0] mirror_elems [DEPTH];
	int mirror_count = 0;

	search_word_t pending_results [$];
	stim_row_t directed_rows [$];
	search_word_t got_word;
	int errors = 0;
	int idle_cycles = 0;
	int rx_cycle = 0;
	int burst_left = 0;
	int random_sent = 0;
	int n_search = 0, n_hit = 0, n_append = 0, n_dropped = 0, n_clear = 0;

	rotated_sorted_array_search_core #(.DEPTH(DEPTH)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found     (found),
		.position  (position),
		.status    (status)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int bisect_range(input int lo_i, input int hi_i,
			input logic signed [VALUE_W-1:0] key);
		int lo;
		int hi;
		int m;
		lo = lo_i;
		hi = hi_i;
		while (lo <= hi) begin
			m = (lo + hi) / 2;
			if (mirror_elems[m] > key)
				hi = m - 1;
			else if (mirror_elems[m] < key)
				lo = m + 1;
			else
				return m;
		end
		return -1;
	endfunction

	function automatic int locate_key(input logic signed [VALUE_W-1:0] key);
		int lo;
		int hi;
		int m;
		lo = 0;
		hi = mirror_count - 1;
		while (lo <= hi) begin
			if (mirror_elems[lo] <= mirror_elems[hi])
				return bisect_range(lo, hi, key);
			m = (lo + hi) / 2;
			if (mirror_elems[lo] <= mirror_elems[m]) begin
				if (key >= mirror_elems[lo] && key <= mirror_elems[m])
					return bisect_range(lo, m, key);
			end else if (key >= mirror_elems[lo] || key <= mirror_elems[m]) begin
				// target lies in the wrapped left half
				hi = m;
				continue;
			end
			lo = m + 1;
		end
		return -1;
	endfunction

	function automatic search_word_t predict_word(input logic [1:0] m,
			input logic signed [VALUE_W-1:0] v);
		search_word_t r;
		int idx;
		r.found = 1'b0;
		r.position = '0;
		r.status = STATUS_OK;
		case (m)
			MODE_CLEAR: begin
				mirror_count = 0;
				n_clear++;
			end
			MODE_APPEND: begin
				n_append++;
				if (mirror_count >= DEPTH) begin
					r.status = STATUS_FULL;
					n_dropped++;
				end else begin
					mirror_elems[mirror_count] = v;
					mirror_count++;
				end
			end
			MODE_SEARCH: begin
				n_search++;
				idx = locate_key(v);
				if (idx >= 0) begin
					r.found = 1'b1;
					r.position = idx[POS_W-1:0];
					n_hit++;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// drive one word, keeping valid high across a burst
	task automatic send_word(input logic [1:0] m, input logic signed [VALUE_W-1:0] v,
			input bit typed, input search_word_t typed_res);
		int gap;
		search_word_t r;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		mode <= m;
		value <= v;
		do @(posedge clk); while (!in_ready);
		r = predict_word(m, v);
		if (typed)
			pending_results.push_back(typed_res);
		else
			pending_results.push_back(r);
		burst_left--;
		if (burst_left == 0)
			in_valid <= 1'b0;
	endtask

	task automatic send_plain(input logic [1:0] m, input logic signed [VALUE_W-1:0] v);
		search_word_t none;
		none = '{1'b0, '0, STATUS_OK};
		send_word(m, v, 1'b0, none);
		if (m != MODE_UNUSED)
			random_sent++;
	endtask

	task automatic add_row(input logic [1:0] m, input logic signed [VALUE_W-1:0] v,
			input bit typed, input logic f, input logic [POS_W-1:0] p, input logic s);
		stim_row_t row;
		row.m = m;
		row.v = v;
		row.typed = typed;
		row.res = '{f, p, s};
		directed_rows.push_back(row);
	endtask

	// pick a search target, mostly one that is held
	function automatic logic signed [VALUE_W-1:0] pick_target();
		int sel;
		logic signed [VALUE_W-1:0] t;
		sel = $urandom_range(0, 9);
		t = VALUE_W'($urandom);
		if (mirror_count > 0 && sel < 6)
			t = mirror_elems[$urandom_range(0, mirror_count - 1)];
		else if (mirror_count > 0 && sel == 6)
			t = VALUE_W'(mirror_elems[$urandom_range(0, mirror_count - 1)]
				+ ($urandom_range(0, 1) ? 1 : -1));
		else if (sel == 7)
			t = 16'sh8000;
		else if (sel == 8)
			t = 16'sh7fff;
		return t;
	endfunction

	// receiver: stall pattern changes with the cycle counter, through four patterns
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		case ((rx_cycle / 256) % 4)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= (rx_cycle % 5) < 2;
			default: out_ready <= ($urandom_range(0, 11) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				got_word = pending_results.pop_front();
				if (found !== got_word.found) begin
					$error("found: expected %0d, got %0d", got_word.found, found);
					errors++;
				end
				if (position !== got_word.position) begin
					$error("position: expected %0d, got %0d", got_word.position, position);
					errors++;
				end
				if (status !== got_word.status) begin
					$error("status: expected %0d, got %0d", got_word.status, status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic signed [VALUE_W-1:0] run [$];
		logic signed [VALUE_W-1:0] tmp;
		int kind, len, shift, step, j;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		add_row(MODE_SEARCH, 16'sh0000, 1, 1'b0, '0, STATUS_OK);
		add_row(MODE_UNUSED, 16'shffff, 1, 1'b0, '0, STATUS_OK);
		add_row(MODE_APPEND, 16'sh7fff, 1, 1'b0, '0, STATUS_OK);
		add_row(MODE_SEARCH, 16'sh7fff, 1, 1'b1, '0, STATUS_OK);
		add_row(MODE_APPEND, 16'sh8000, 1, 1'b0, '0, STATUS_OK);
		add_row(MODE_APPEND, -16'sd5, 1, 1'b0, '0, STATUS_OK);
		add_row(MODE_APPEND, 16'sd100, 1, 1'b0, '0, STATUS_OK);
		add_row(MODE_SEARCH, 16'sh8000, 0, 1'b0, '0, STATUS_OK);
		add_row(MODE_SEARCH, 16'sd100, 0, 1'b0, '0, STATUS_OK);
		add_row(MODE_SEARCH, 16'sh7fff, 0, 1'b0, '0, STATUS_OK);
		add_row(MODE_SEARCH, 16'sd7, 0, 1'b0, '0, STATUS_OK);
		add_row(MODE_SEARCH, 16'sh8001, 0, 1'b0, '0, STATUS_OK);
		add_row(MODE_CLEAR, 16'sh5a5a, 1, 1'b0, '0, STATUS_OK);
		add_row(MODE_SEARCH, 16'sh8000, 1, 1'b0, '0, STATUS_OK);
		add_row(MODE_APPEND, 16'sd5, 1, 1'b0, '0, STATUS_OK);
		add_row(MODE_APPEND, 16'sd5, 1, 1'b0, '0, STATUS_OK);
		add_row(MODE_APPEND, 16'sd5, 1, 1'b0, '0, STATUS_OK);
		add_row(MODE_APPEND, 16'sd1, 1, 1'b0, '0, STATUS_OK);
		add_row(MODE_SEARCH, 16'sd5, 0, 1'b0, '0, STATUS_OK);
		add_row(MODE_SEARCH, 16'sd1, 0, 1'b0, '0, STATUS_OK);
		add_row(MODE_SEARCH, 16'sd3, 0, 1'b0, '0, STATUS_OK);
		add_row(MODE_UNUSED, 16'sh5555, 1, 1'b0, '0, STATUS_OK);
		add_row(MODE_CLEAR, 16'shaaaa, 1, 1'b0, '0, STATUS_OK);
		foreach (directed_rows[i])
			send_word(directed_rows[i].m, directed_rows[i].v, directed_rows[i].typed,
				directed_rows[i].res);

		// one rotated ascending run spread over the whole value range, then searches, more appends and a clear
		step = 65536 / FILL_WORDS;
		shift = $urandom_range(1, FILL_WORDS - 1);
		for (int i = 0; i < FILL_WORDS; i++) begin
			j = (i + shift) % FILL_WORDS;
			tmp = VALUE_W'(j * step - 32768);
			send_plain(MODE_APPEND, tmp);
		end
		send_plain(MODE_SEARCH, mirror_elems[FILL_WORDS - 1]);
		send_plain(MODE_SEARCH, mirror_elems[0]);
		for (int i = 0; i < 40; i++)
			send_plain(MODE_SEARCH, pick_target());
		for (int i = 0; i < 3; i++)
			send_plain(MODE_APPEND, VALUE_W'($urandom));
		send_plain(MODE_SEARCH, pick_target());
		send_plain(MODE_CLEAR, VALUE_W'($urandom));

		random_sent = 0;
		while (random_sent < RANDOM_WORDS) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				// well-formed: clear, rotated ascending run, searches
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 200)
					: $urandom_range(1, 24);
				run.delete();
				for (int i = 0; i < len; i++) begin
					// narrow range now and then to force duplicates
					tmp = VALUE_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) - 4
						: $urandom);
					run.push_back(tmp);
				end
				run.sort();
				shift = $urandom_range(0, len - 1);
				send_plain(MODE_CLEAR, VALUE_W'($urandom));
				for (int i = 0; i < len; i++)
					send_plain(MODE_APPEND, run[(i + shift) % len]);
				repeat ($urandom_range(1, 12))
					send_plain(MODE_SEARCH, pick_target());
			end else if (kind == 7) begin
				repeat ($urandom_range(1, 8))
					send_plain(2'($urandom_range(0, 3)), VALUE_W'($urandom));
			end else begin
				// unsorted appends on top of whatever is held
				repeat ($urandom_range(1, 6))
					send_plain(MODE_APPEND, VALUE_W'($urandom));
				repeat ($urandom_range(1, 4))
					send_plain(MODE_SEARCH, pick_target());
			end
		end
		if (burst_left != 0)
			in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d searches (%0d hits), %0d appends (%0d dropped on full), %0d clears",
			n_search, n_hit, n_append, n_dropped, n_clear);
		$display("including a %0d-entry run over the full value range and %0d random words",
			FILL_WORDS, random_sent);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
